// ===== sv/nec_pkg.sv =====
// Shared constants for the necklace counter.
`default_nettype none
package nec_pkg;
   localparam int LEN_W = 21;
   localparam int COLOR_W = 30;
   localparam int MAX_LENGTH_DEF = 1048576;
   localparam logic [COLOR_W-1:0] PRIME_MOD = 30'd1000000007;
   localparam logic [COLOR_W-1:0] FERMAT_EXP = 30'd1000000005;
endpackage
`default_nettype wire

// ===== sv/nec_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface nec_req_if import nec_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [LEN_W-1:0]     cycle_length;
   logic [COLOR_W-1:0]   color_count;
   modport source (output valid, output cycle_length, output color_count, input ready);
   modport sink   (input valid, input cycle_length, input color_count, output ready);
endinterface

interface nec_rsp_if import nec_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [COLOR_W-1:0]   necklace_count;
   modport source (output valid, output necklace_count, input ready);
   modport sink   (input valid, input necklace_count, output ready);
endinterface
`default_nettype wire

// ===== sv/nec_div.sv =====
// Bit-serial restoring divider giving quotient and remainder.
`default_nettype none
module nec_div import nec_pkg::*; #(
   parameter int W = LEN_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);
   localparam int CW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W:0]      rem_ff, rem_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    dvs_ff, dvs_in;
   logic [W:0]      shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff[W-1:0];
endmodule
`default_nettype wire

// ===== sv/nec_mulmod.sv =====
// Bit-serial multiplier modulo the prime, one bit of the first operand per cycle.
`default_nettype none
module nec_mulmod import nec_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COLOR_W-1:0] op_a,
   input  wire logic [COLOR_W-1:0] op_b,
   output logic                    done,
   output logic [COLOR_W-1:0]      product
);
   localparam int CW = $clog2(COLOR_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [COLOR_W-1:0]  acc_ff, acc_in;
   logic [COLOR_W-1:0]  a_ff, a_in;
   logic [COLOR_W-1:0]  b_ff, b_in;
   logic [COLOR_W:0]    dbl;
   logic [COLOR_W:0]    sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, PRIME_MOD}) begin
         dbl = dbl - {1'b0, PRIME_MOD};
      end
      sum = dbl + (a_ff[COLOR_W-1] ? {1'b0, b_ff} : '0);
      if (sum >= {1'b0, PRIME_MOD}) begin
         sum = sum - {1'b0, PRIME_MOD};
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(COLOR_W);
         acc_in = '0;
         a_in = op_a;
         b_in = op_b;
      end else if (busy_ff) begin
         acc_in = sum[COLOR_W-1:0];
         a_in = {a_ff[COLOR_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ===== sv/necklace_count_mod_prime.sv =====
// Necklace counter top level: divisor scan, totients and modular powers.
// Latency is data dependent: it grows with the divisor candidates, totient trial factors and modular multiplies.
// One request is handled at a time; the next request can be taken in the cycle after the response is accepted.
// Reset is synchronous and active high; it clears the sequencer and the response.
`default_nettype none
module necklace_count_mod_prime import nec_pkg::*; #(
   parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   nec_req_if.sink   req_chan,
   nec_rsp_if.source rsp_chan
);
   localparam int LW = ($clog2(MAX_LENGTH + 1) > LEN_W) ? $clog2(MAX_LENGTH + 1) : LEN_W;

   typedef enum logic [4:0] {
      S_IDLE, S_D_CHECK, S_D_WAIT, S_T_INIT, S_T_CHECK, S_T_DIV1, S_T_DIV2,
      S_T_DIV3, S_T_TAIL, S_T_DIV4, S_T_DONE, S_P_STEP, S_P_MUL1, S_P_MUL2,
      S_P_END, S_S_WAIT, S_F_WAIT, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      n_ff, n_in, d_ff, d_in, e_ff, e_in, k_ff, k_in;
   logic [LW-1:0]      rest_ff, rest_in, res_ff, res_in, p_ff, p_in, tot_ff, tot_in;
   logic [COLOR_W-1:0] m_ff, m_in, base_ff, base_in, acc_ff, acc_in, exp_ff, exp_in;
   logic [COLOR_W-1:0] sum_ff, sum_in, count_ff, count_in;
   logic               second_ff, second_in, final_ff, final_in;
   logic               div_start_ff, div_start_in, mul_start_ff, mul_start_in;
   logic [LW-1:0]      div_a_ff, div_a_in, div_b_ff, div_b_in;
   logic [COLOR_W-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               div_done, mul_done;
   logic [LW-1:0]      div_q, div_r;
   logic [COLOR_W-1:0] mul_p;
   logic [LW:0]        len_ext;
   logic [2*LW-1:0]    d_sq, p_sq;
   logic [COLOR_W:0]   acc_sum;

   nec_div #(.W(LW)) u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend(div_a_ff), .divisor(div_b_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   nec_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff),
      .op_a(mul_a_ff), .op_b(mul_b_ff), .done(mul_done), .product(mul_p)
   );

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; e_in = e_ff; k_in = k_ff;
      rest_in = rest_ff; res_in = res_ff; p_in = p_ff; tot_in = tot_ff;
      m_in = m_ff; base_in = base_ff; acc_in = acc_ff; exp_in = exp_ff;
      sum_in = sum_ff; count_in = count_ff;
      second_in = second_ff; final_in = final_ff;
      div_start_in = 1'b0; div_a_in = div_a_ff; div_b_in = div_b_ff;
      mul_start_in = 1'b0; mul_a_in = mul_a_ff; mul_b_in = mul_b_ff;
      rsp_valid_in = rsp_valid_ff;
      len_ext = (LW + 1)'(req_chan.cycle_length);
      d_sq = (2 * LW)'(d_ff) * (2 * LW)'(d_ff);
      p_sq = (2 * LW)'(p_ff) * (2 * LW)'(p_ff);
      acc_sum = {1'b0, sum_ff} + {1'b0, mul_p};
      if (acc_sum >= {1'b0, PRIME_MOD}) begin
         acc_sum = acc_sum - {1'b0, PRIME_MOD};
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (len_ext > (LW + 1)'(MAX_LENGTH)) begin
                  n_in = LW'(MAX_LENGTH);
               end else begin
                  n_in = len_ext[LW-1:0];
               end
               if (req_chan.color_count >= PRIME_MOD) begin
                  m_in = req_chan.color_count - PRIME_MOD;
               end else begin
                  m_in = req_chan.color_count;
               end
               d_in = LW'(1);
               sum_in = '0;
               if (req_chan.cycle_length == '0) begin
                  count_in = '0;
                  rsp_valid_in = 1'b1;
                  state_in = S_OUT;
               end else begin
                  state_in = S_D_CHECK;
               end
            end
         end
         S_D_CHECK: begin
            if (d_sq > (2 * LW)'(n_ff)) begin
               base_in = COLOR_W'(n_ff);
               acc_in = COLOR_W'(1);
               exp_in = FERMAT_EXP;
               final_in = 1'b1;
               state_in = S_P_STEP;
            end else begin
               div_start_in = 1'b1;
               div_a_in = n_ff;
               div_b_in = d_ff;
               state_in = S_D_WAIT;
            end
         end
         S_D_WAIT: begin
            if (div_done) begin
               if (div_r == '0) begin
                  e_in = div_q;
                  k_in = div_q;
                  second_in = 1'b0;
                  state_in = S_T_INIT;
               end else begin
                  d_in = d_ff + 1'b1;
                  state_in = S_D_CHECK;
               end
            end
         end
         S_T_INIT: begin
            rest_in = k_ff;
            res_in = k_ff;
            p_in = LW'(2);
            state_in = S_T_CHECK;
         end
         S_T_CHECK: begin
            if (p_sq > (2 * LW)'(rest_ff)) begin
               state_in = S_T_TAIL;
            end else begin
               div_start_in = 1'b1;
               div_a_in = rest_ff;
               div_b_in = p_ff;
               state_in = S_T_DIV1;
            end
         end
         S_T_DIV1, S_T_DIV2: begin
            if (div_done) begin
               if (div_r == '0) begin
                  rest_in = div_q;
                  div_start_in = 1'b1;
                  div_a_in = div_q;
                  div_b_in = p_ff;
                  state_in = S_T_DIV2;
               end else if (state_ff == S_T_DIV2) begin
                  div_start_in = 1'b1;
                  div_a_in = res_ff;
                  div_b_in = p_ff;
                  state_in = S_T_DIV3;
               end else begin
                  p_in = p_ff + 1'b1;
                  state_in = S_T_CHECK;
               end
            end
         end
         S_T_DIV3: begin
            if (div_done) begin
               res_in = res_ff - div_q;
               p_in = p_ff + 1'b1;
               state_in = S_T_CHECK;
            end
         end
         S_T_TAIL: begin
            if (rest_ff > LW'(1)) begin
               div_start_in = 1'b1;
               div_a_in = res_ff;
               div_b_in = rest_ff;
               state_in = S_T_DIV4;
            end else begin
               state_in = S_T_DONE;
            end
         end
         S_T_DIV4: begin
            if (div_done) begin
               res_in = res_ff - div_q;
               state_in = S_T_DONE;
            end
         end
         S_T_DONE: begin
            tot_in = res_ff;
            base_in = m_ff;
            acc_in = COLOR_W'(1);
            exp_in = second_ff ? COLOR_W'(e_ff) : COLOR_W'(d_ff);
            final_in = 1'b0;
            state_in = S_P_STEP;
         end
         S_P_STEP: begin
            if (exp_ff == '0) begin
               state_in = S_P_END;
            end else if (exp_ff[0]) begin
               mul_start_in = 1'b1;
               mul_a_in = acc_ff;
               mul_b_in = base_ff;
               state_in = S_P_MUL1;
            end else begin
               mul_start_in = 1'b1;
               mul_a_in = base_ff;
               mul_b_in = base_ff;
               state_in = S_P_MUL2;
            end
         end
         S_P_MUL1: begin
            if (mul_done) begin
               acc_in = mul_p;
               mul_start_in = 1'b1;
               mul_a_in = base_ff;
               mul_b_in = base_ff;
               state_in = S_P_MUL2;
            end
         end
         S_P_MUL2: begin
            if (mul_done) begin
               base_in = mul_p;
               exp_in = {1'b0, exp_ff[COLOR_W-1:1]};
               state_in = S_P_STEP;
            end
         end
         S_P_END: begin
            mul_start_in = 1'b1;
            mul_b_in = acc_ff;
            if (final_ff) begin
               mul_a_in = sum_ff;
               state_in = S_F_WAIT;
            end else begin
               mul_a_in = COLOR_W'(tot_ff);
               state_in = S_S_WAIT;
            end
         end
         S_S_WAIT: begin
            if (mul_done) begin
               sum_in = acc_sum[COLOR_W-1:0];
               if (!second_ff && (e_ff != d_ff)) begin
                  second_in = 1'b1;
                  k_in = d_ff;
                  state_in = S_T_INIT;
               end else begin
                  d_in = d_ff + 1'b1;
                  state_in = S_D_CHECK;
               end
            end
         end
         S_F_WAIT: begin
            if (mul_done) begin
               count_in = mul_p;
               rsp_valid_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_start_ff <= div_start_in;
         mul_start_ff <= mul_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in; d_ff <= d_in; e_ff <= e_in; k_ff <= k_in;
      rest_ff <= rest_in; res_ff <= res_in; p_ff <= p_in; tot_ff <= tot_in;
      m_ff <= m_in; base_ff <= base_in; acc_ff <= acc_in; exp_ff <= exp_in;
      sum_ff <= sum_in; count_ff <= count_in;
      second_ff <= second_in; final_ff <= final_in;
      div_a_ff <= div_a_in; div_b_ff <= div_b_in;
      mul_a_ff <= mul_a_in; mul_b_ff <= mul_b_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.necklace_count = count_ff;

`ifndef SYNTH
   // A request and a pending response never coexist.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted while a response is pending");

   // The response is always reduced below the modulus.
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.necklace_count < PRIME_MOD))
      else $error("response not reduced");

   // The divider and the multiplier are never launched together.
   a_one_launch: assert property (@(posedge clock) disable iff (reset)
      !(div_start_ff && mul_start_ff))
      else $error("two units launched at once");

   // After a request is taken, the block stops taking requests.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready stayed high after a request");
`endif
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for necklace_count_mod_prime: directed and random requests checked against a local predictor.
`timescale 1ns / 100ps
module testbench;
   import nec_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0]   cycle_length;
      logic [COLOR_W-1:0] color_count;
   } bead_req_type;

   localparam longint unsigned PMOD = 64'd1000000007;
   localparam int PRESSURE_CYCLES = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nec_req_if req_chan ();
   nec_rsp_if rsp_chan ();

   necklace_count_mod_prime dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bead_req_type       pending_reqs[$];
   logic [COLOR_W-1:0] expected_counts[$];
   logic [COLOR_W-1:0] inflight_count;
   int                 errors = 0;
   int                 responses = 0;
   int                 sent = 0;
   int                 send_gap = 0;
   int                 recv_gap = 0;
   int                 pressure_left = 0;
   bit                 pressure_done = 1'b0;
   bit                 all_queued = 1'b0;

   function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return (a * b) % PMOD;
   endfunction

   function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned x);
      longint unsigned acc;
      acc = 1;
      b = b % PMOD;
      while (x != 0) begin
         if (x[0]) acc = mul_mod(acc, b);
         b = mul_mod(b, b);
         x = x >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned totient(longint unsigned k);
      longint unsigned res, rest, p;
      res = k;
      rest = k;
      for (p = 2; p * p <= rest; p++) begin
         if (rest % p == 0) begin
            while (rest % p == 0) rest = rest / p;
            res = res - res / p;
         end
      end
      if (rest > 1) res = res - res / rest;
      return res;
   endfunction

   function automatic logic [COLOR_W-1:0] count_necklaces(bead_req_type r);
      longint unsigned n, m, total, d, e;
      n = r.cycle_length;
      m = longint'(r.color_count) % PMOD;
      total = 0;
      if (n > MAX_LENGTH_DEF) n = MAX_LENGTH_DEF;
      if (n == 0) return '0;
      for (d = 1; d * d <= n; d++) begin
         if (n % d == 0) begin
            e = n / d;
            total = (total + mul_mod(totient(e) % PMOD, pow_mod(m, d))) % PMOD;
            if (e != d)
               total = (total + mul_mod(totient(d) % PMOD, pow_mod(m, e))) % PMOD;
         end
      end
      total = mul_mod(total, pow_mod(n, PMOD - 2));
      return total[COLOR_W-1:0];
   endfunction

   function automatic void queue_req(longint unsigned n, longint unsigned m);
      bead_req_type r;
      r.cycle_length = n[LEN_W-1:0];
      r.color_count = m[COLOR_W-1:0];
      pending_reqs.push_back(r);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      bead_req_type r;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.cycle_length <= '0;
         req_chan.color_count <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_counts.push_back(inflight_count);
            sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 15 && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 6) - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               r = pending_reqs.pop_front();
               inflight_count <= count_necklaces(r);
               req_chan.cycle_length <= r.cycle_length;
               req_chan.color_count <= r.color_count;
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and ready control.
   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses++;
            if (expected_counts.size() == 0) begin
               $error("necklace_count: unexpected response %0d", rsp_chan.necklace_count);
               errors++;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_chan.necklace_count !== want) begin
                  $error("necklace_count: expected %0d, actual %0d",
                         want, rsp_chan.necklace_count);
                  errors++;
               end
            end
         end
         if (!pressure_done && responses == 20) begin
            pressure_done = 1'b1;
            pressure_left = PRESSURE_CYCLES;
         end
         if (pressure_left > 0) begin
            pressure_left--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (!(all_queued && pending_reqs.size() <= 15)
                      && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 6) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      #800_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      longint unsigned n, m;
      queue_req(0, 5);
      queue_req(1, 1);
      queue_req(1, PMOD - 1);
      queue_req(6, PMOD);
      queue_req(5, 64'h3FFF_FFFF);
      queue_req(2, 2);
      queue_req(3, 3);
      queue_req(4, 2);
      queue_req(12, 7);
      queue_req(30, 1);
      queue_req(31, 123456789);
      queue_req(64'h1F_FFFF, 2);
      queue_req(MAX_LENGTH_DEF, 3);
      queue_req(60, PMOD + 1);
      queue_req(7, 0);
      for (int i = 0; i < 85; i++) begin
         if (i % 30 == 29) n = $urandom_range(0, 2 ** LEN_W - 1);
         else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 4096);
         else n = $urandom_range(1, 64);
         case ($urandom_range(0, 3))
            0: m = $urandom_range(1, 100);
            1: m = PMOD - 3 + $urandom_range(0, 6);
            default: m = {$urandom} & 32'h3FFF_FFFF;
         endcase
         queue_req(n, m);
      end
      all_queued = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_chan.valid || expected_counts.size() != 0)
         @(posedge clock);
      repeat (300000) @(posedge clock);
      $display("Sent %0d requests including zero, saturated and unreduced-color cases;", sent);
      $display("checked %0d responses with a long response stall.", responses);
      if (errors == 0 && expected_counts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
